>>> hw/rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the sparse polynomial adder: term capacity,
// index widths, command codes and the stored term format.
// ----------------------------------------------------------------------------
package spa_pkg;

	// Terms each polynomial list can hold
	localparam int MAX_TERMS = 32;

	// Term memory address width and fill counter width (counter holds MAX_TERMS)
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);

	// Field widths
	localparam int COEF_W = 16;
	localparam int EXP_W  = 10;
	localparam int SUM_W  = COEF_W + 1;

	// Command codes carried in the kind field
	localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
	localparam logic [1:0] KIND_RUN         = 2'd2;

	// One stored term
	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic [EXP_W-1:0]         expon;
	} term_t;

endpackage

>>> hw/rtl/sparse_polynomial_adder.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// Loads two descending-exponent term lists into two term memories, then on a
// run command merges them, adding coefficients of equal exponents, dropping zero
// sums. One result per merged term, last one marked, or one empty_res item.
// ----------------------------------------------------------------------------
// Loads: one transaction per cycle while idle, stored at the accepting clock edge.
// Run: the first terms are read at the accepting edge, then one merge step per
//   cycle while the output is not stalled (each term memory read is registered);
//   once both lists are exhausted, the held final term is emitted, marked last.
// Reset clears fill counts, overflow flag and control; memories are not cleared.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        kind,
	input  logic signed [spa_pkg::COEF_W-1:0] coef,
	input  logic [spa_pkg::EXP_W-1:0]         expon,
	// result channel
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic signed [spa_pkg::SUM_W-1:0]  sum_coef,
	output logic [spa_pkg::EXP_W-1:0]         sum_expon,
	output logic                              last,
	output logic                              empty_res,
	output logic                              overflow
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MERGE,
		S_FLUSH
	} state_t;

	state_t state_q;

	// term memories
	spa_pkg::term_t first_mem_q  [spa_pkg::MAX_TERMS];
	spa_pkg::term_t second_mem_q [spa_pkg::MAX_TERMS];
	spa_pkg::term_t first_rd_q;
	spa_pkg::term_t second_rd_q;

	logic [spa_pkg::CW-1:0] first_cnt_q, second_cnt_q;
	logic [spa_pkg::CW-1:0] a_q, b_q, a_d, b_d;
	logic                   drop_q;

	// pending term, held until it is known whether it is the last one
	logic                              pend_v_q;
	logic signed [spa_pkg::SUM_W-1:0]  pend_coef_q;
	logic [spa_pkg::EXP_W-1:0]         pend_exp_q;

	// output register
	logic                              out_v_q;
	logic signed [spa_pkg::SUM_W-1:0]  out_coef_q;
	logic [spa_pkg::EXP_W-1:0]         out_exp_q;
	logic                              out_last_q;
	logic                              out_empty_q;
	logic                              out_ovf_q;

	logic req_fire, out_free;
	logic wr_first, wr_second;
	logic a_lt, b_lt, merge_done;
	logic cand_v;
	logic signed [spa_pkg::SUM_W-1:0] cand_coef, add_sum;
	logic [spa_pkg::EXP_W-1:0]        cand_exp;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !out_v_q || res_ready;

	assign wr_first  = req_fire && (kind == spa_pkg::KIND_LOAD_FIRST) &&
		(first_cnt_q < spa_pkg::CW'(spa_pkg::MAX_TERMS));
	assign wr_second = req_fire && (kind == spa_pkg::KIND_LOAD_SECOND) &&
		(second_cnt_q < spa_pkg::CW'(spa_pkg::MAX_TERMS));

	assign a_lt = a_q < first_cnt_q;
	assign b_lt = b_q < second_cnt_q;
	assign add_sum = {first_rd_q.coef[spa_pkg::COEF_W-1], first_rd_q.coef} +
		{second_rd_q.coef[spa_pkg::COEF_W-1], second_rd_q.coef};

	// Pick the next merged term and advance the list indexes
	always_comb begin
		cand_v     = 1'b0;
		cand_coef  = '0;
		cand_exp   = '0;
		a_d        = a_q;
		b_d        = b_q;
		merge_done = 1'b0;
		if (state_q == S_IDLE) begin
			a_d = '0;
			b_d = '0;
		end else if (state_q == S_MERGE && out_free) begin
			if (a_lt && b_lt) begin
				if (first_rd_q.expon == second_rd_q.expon) begin
					cand_v    = (add_sum != '0);
					cand_coef = add_sum;
					cand_exp  = first_rd_q.expon;
					a_d       = a_q + 1'b1;
					b_d       = b_q + 1'b1;
				end else if (first_rd_q.expon > second_rd_q.expon) begin
					cand_v    = 1'b1;
					cand_coef = {first_rd_q.coef[spa_pkg::COEF_W-1], first_rd_q.coef};
					cand_exp  = first_rd_q.expon;
					a_d       = a_q + 1'b1;
				end else begin
					cand_v    = 1'b1;
					cand_coef = {second_rd_q.coef[spa_pkg::COEF_W-1], second_rd_q.coef};
					cand_exp  = second_rd_q.expon;
					b_d       = b_q + 1'b1;
				end
			end else if (a_lt) begin
				cand_v    = 1'b1;
				cand_coef = {first_rd_q.coef[spa_pkg::COEF_W-1], first_rd_q.coef};
				cand_exp  = first_rd_q.expon;
				a_d       = a_q + 1'b1;
			end else if (b_lt) begin
				cand_v    = 1'b1;
				cand_coef = {second_rd_q.coef[spa_pkg::COEF_W-1], second_rd_q.coef};
				cand_exp  = second_rd_q.expon;
				b_d       = b_q + 1'b1;
			end else begin
				merge_done = 1'b1;
			end
		end
	end

	// First term memory: write on load, read the next index
	always_ff @(posedge clk) begin
		if (wr_first) begin
			first_mem_q[first_cnt_q[spa_pkg::AW-1:0]] <= '{coef: coef, expon: expon};
		end
		first_rd_q <= first_mem_q[a_d[spa_pkg::AW-1:0]];
	end

	// Second term memory
	always_ff @(posedge clk) begin
		if (wr_second) begin
			second_mem_q[second_cnt_q[spa_pkg::AW-1:0]] <= '{coef: coef, expon: expon};
		end
		second_rd_q <= second_mem_q[b_d[spa_pkg::AW-1:0]];
	end

	// Output payload: hold while stalled, load on push or final item
	always_ff @(posedge clk) begin
		if (state_q == S_MERGE && cand_v && pend_v_q) begin
			out_coef_q  <= pend_coef_q;
			out_exp_q   <= pend_exp_q;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
			out_ovf_q   <= drop_q;
		end else if (state_q == S_FLUSH && out_free) begin
			out_coef_q  <= pend_v_q ? pend_coef_q : '0;
			out_exp_q   <= pend_v_q ? pend_exp_q : '0;
			out_last_q  <= 1'b1;
			out_empty_q <= !pend_v_q;
			out_ovf_q   <= drop_q;
		end
		if (state_q == S_MERGE && cand_v) begin
			pend_coef_q <= cand_coef;
			pend_exp_q  <= cand_exp;
		end
	end

	// Sequencer, counts, flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			drop_q       <= 1'b0;
			a_q          <= '0;
			b_q          <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			a_q <= a_d;
			b_q <= b_d;
			if (res_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (kind == spa_pkg::KIND_RUN) begin
							state_q <= S_MERGE;
						end else if (kind == spa_pkg::KIND_LOAD_FIRST) begin
							if (wr_first) first_cnt_q <= first_cnt_q + 1'b1;
							else drop_q <= 1'b1;
						end else if (kind == spa_pkg::KIND_LOAD_SECOND) begin
							if (wr_second) second_cnt_q <= second_cnt_q + 1'b1;
							else drop_q <= 1'b1;
						end
					end
				end
				S_MERGE: begin
					if (cand_v) begin
						pend_v_q <= 1'b1;
						if (pend_v_q) out_v_q <= 1'b1;
					end
					if (merge_done) state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (out_free) begin
						out_v_q      <= 1'b1;
						pend_v_q     <= 1'b0;
						first_cnt_q  <= '0;
						second_cnt_q <= '0;
						drop_q       <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = out_v_q;
	assign sum_coef  = out_coef_q;
	assign sum_expon = out_exp_q;
	assign last      = out_last_q;
	assign empty_res = out_empty_q;
	assign overflow  = out_ovf_q;

endmodule
